@@ hw/rtl/fds_pkg.sv @@
// Shared types and constants for the fall-detection sequencer.
// No dependencies; all other files in hw/rtl but fds_in_if refer to this package by scoped names.
package fds_pkg;

  // Sequencer phase, as reported in each result
  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_SETTLE    = 3'd1,
    PH_CHECK     = 3'd2,
    PH_POSTURE   = 3'd3,
    PH_ALARM     = 3'd4,
    PH_CONFIRMED = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_SUSPECTED = 3'd1,
    EV_MOTION    = 3'd2,
    EV_POSTURE   = 3'd3,
    EV_ALARM     = 3'd4,
    EV_CANCELLED = 3'd5,
    EV_CONFIRMED = 3'd6,
    EV_RESOLVED  = 3'd7
  } event_t;

  // Request operation codes; code 3 has no meaning and is ignored
  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_TICK   = 2'd1;
  localparam logic [1:0] OP_KEY    = 2'd2;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_SVM_HIGH       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STILL_BAND     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_CHANGE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE_SAMPLES = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CHECK_SAMPLES  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ALARM_TICKS    = 3'd5;

  // Register reset values
  localparam logic [15:0] SVM_HIGH_RST       = 16'd8192;
  localparam logic [15:0] STILL_BAND_RST     = 16'd1024;
  localparam logic [14:0] ANGLE_CHANGE_RST   = 15'd3840;
  localparam logic [7:0]  SETTLE_SAMPLES_RST = 8'd10;
  localparam logic [7:0]  CHECK_SAMPLES_RST  = 8'd10;
  localparam logic [7:0]  ALARM_TICKS_RST    = 8'd30;

  // 1 g in 1/4096 g units
  localparam logic [16:0] ONE_G = 17'd4096;

endpackage

@@ hw/rtl/fds_in_if.sv @@
// Request channel of the fall-detection sequencer: valid/ready plus item fields.
// Depends on nothing; its field widths are written out here, not taken from fds_pkg.
interface fds_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic [15:0]        svm;
  logic signed [14:0] angle;

  modport source (output valid, output operation, output svm, output angle, input ready);
  modport sink   (input valid, input operation, input svm, input angle, output ready);
endinterface

@@ hw/rtl/fds_out_if.sv @@
// Result channel of the fall-detection sequencer: valid/ready plus result fields.
// Uses fds_pkg for the phase and event types.
interface fds_out_if;
  logic                valid;
  logic                ready;
  fds_pkg::phase_t     phase;
  logic                buzzer;
  logic                fall_latched;
  logic                send_alert;
  fds_pkg::event_t     event_res;

  modport source (output valid, output phase, output buzzer, output fall_latched,
                  output send_alert, output event_res, input ready);
  modport sink   (input valid, input phase, input buzzer, input fall_latched,
                  input send_alert, input event_res, output ready);
endinterface

@@ hw/rtl/fall_detect_sequencer_unit.sv @@
// Fall-detection sequencer top level: phase sequencer, counters and result register.
// Depends on fds_pkg, fds_in_if and fds_out_if.
//
// Each request (sensor sample, alarm tick or key press) gives exactly one result,
// which appears in the result register on the cycle after the request is taken.
// One request is taken every cycle unless the sink stalls: ready is high whenever
// the result register is empty or its current result is being taken in the same
// cycle, so the rate is set by that single result register and the downstream
// side alone. All the work for a request is a few compares and an 8-bit counter
// update. Configuration writes must only be made while no result is outstanding.
module fall_detect_sequencer_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [fds_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [fds_pkg::CFG_DATA_W-1:0]       cfg_data,
  fds_in_if.sink                               req_in,
  fds_out_if.source                            res_out
);

  // Configuration registers
  logic [15:0] svm_high;
  logic [15:0] still_band;
  logic [14:0] angle_change;
  logic [7:0]  settle_samples;
  logic [7:0]  check_samples;
  logic [7:0]  alarm_ticks;

  // Sequencer state
  fds_pkg::phase_t    phase_reg;
  fds_pkg::phase_t    phase_next;
  logic signed [14:0] angle_ref;
  logic signed [14:0] angle_ref_next;
  logic [7:0]         step_count;
  logic [7:0]         step_count_next;
  logic               fall_latch;
  logic               fall_latch_next;
  logic               buzzer_reg;
  logic               buzzer_next;

  // Result register
  logic               res_valid;
  fds_pkg::phase_t    res_phase;
  logic               res_buzzer;
  logic               res_fall;
  logic               res_alert;
  fds_pkg::event_t    res_event;

  fds_pkg::event_t    event_c;
  logic               alert_c;

  logic               accept;
  logic               is_sample;
  logic               is_tick;
  logic               is_key;
  logic [7:0]         count_inc;
  logic [7:0]         check_lim;
  logic [7:0]         alarm_lim;
  logic signed [16:0] svm_diff;
  logic [16:0]        svm_dev;
  logic signed [16:0] ang_diff;
  logic [16:0]        ang_chg;
  logic               suspect;
  logic               moving;
  logic               turned;
  logic               settle_done;
  logic               check_done;
  logic               alarm_done;

  assign req_in.ready = !res_valid || res_out.ready;
  assign accept       = req_in.valid && req_in.ready;

  assign is_sample = (req_in.operation == fds_pkg::OP_SAMPLE);
  assign is_tick   = (req_in.operation == fds_pkg::OP_TICK);
  assign is_key    = (req_in.operation == fds_pkg::OP_KEY);

  assign count_inc = step_count + 8'd1;
  // A zero check or alarm count behaves as one
  assign check_lim = (check_samples == 8'd0) ? 8'd1 : check_samples;
  assign alarm_lim = (alarm_ticks == 8'd0) ? 8'd1 : alarm_ticks;

  assign svm_diff = $signed({1'b0, req_in.svm}) - $signed(fds_pkg::ONE_G);
  assign svm_dev  = svm_diff[16] ? 17'(-svm_diff) : 17'(svm_diff);
  assign ang_diff = 17'(req_in.angle) - 17'(angle_ref);
  assign ang_chg  = ang_diff[16] ? 17'(-ang_diff) : 17'(ang_diff);

  assign suspect     = req_in.svm > svm_high;
  assign moving      = svm_dev > {1'b0, still_band};
  assign turned      = ang_chg > {2'b00, angle_change};
  assign settle_done = count_inc >= settle_samples;
  assign check_done  = count_inc >= check_lim;
  assign alarm_done  = count_inc >= alarm_lim;

  // Next phase
  always_comb begin
    phase_next = phase_reg;
    unique case (phase_reg)
      fds_pkg::PH_SETTLE: begin
        if (is_sample && settle_done) phase_next = fds_pkg::PH_CHECK;
      end
      fds_pkg::PH_CHECK: begin
        if (is_sample) begin
          if (moving) phase_next = fds_pkg::PH_IDLE;
          else if (check_done) phase_next = fds_pkg::PH_POSTURE;
        end
      end
      fds_pkg::PH_POSTURE: begin
        if (is_sample) phase_next = turned ? fds_pkg::PH_ALARM : fds_pkg::PH_IDLE;
      end
      fds_pkg::PH_ALARM: begin
        if (is_key) phase_next = fds_pkg::PH_IDLE;
        else if (is_tick && alarm_done) phase_next = fds_pkg::PH_CONFIRMED;
      end
      fds_pkg::PH_CONFIRMED: begin
        if (is_key) phase_next = fds_pkg::PH_IDLE;
      end
      default: begin
        // Unused codes behave as idle
        if (is_sample) begin
          if (!suspect) phase_next = fds_pkg::PH_IDLE;
          else if (settle_samples == 8'd0) phase_next = fds_pkg::PH_CHECK;
          else phase_next = fds_pkg::PH_SETTLE;
        end
      end
    endcase
  end

  // Counter, latches and result fields
  always_comb begin
    step_count_next = step_count;
    angle_ref_next  = angle_ref;
    fall_latch_next = fall_latch;
    buzzer_next     = buzzer_reg;
    event_c         = fds_pkg::EV_NONE;
    alert_c         = 1'b0;
    unique case (phase_reg)
      fds_pkg::PH_SETTLE: begin
        if (is_sample) step_count_next = settle_done ? 8'd0 : count_inc;
      end
      fds_pkg::PH_CHECK: begin
        if (is_sample) begin
          if (moving) begin
            event_c         = fds_pkg::EV_MOTION;
            step_count_next = 8'd0;
          end else begin
            step_count_next = check_done ? 8'd0 : count_inc;
          end
        end
      end
      fds_pkg::PH_POSTURE: begin
        if (is_sample) begin
          step_count_next = 8'd0;
          if (turned) begin
            event_c     = fds_pkg::EV_ALARM;
            buzzer_next = 1'b1;
          end else begin
            event_c = fds_pkg::EV_POSTURE;
          end
        end
      end
      fds_pkg::PH_ALARM: begin
        if (is_key) begin
          event_c         = fds_pkg::EV_CANCELLED;
          buzzer_next     = 1'b0;
          step_count_next = 8'd0;
        end else if (is_tick) begin
          if (alarm_done) begin
            step_count_next = 8'd0;
            fall_latch_next = 1'b1;
            buzzer_next     = 1'b1;
            alert_c         = 1'b1;
            event_c         = fds_pkg::EV_CONFIRMED;
          end else begin
            step_count_next = count_inc;
          end
        end
      end
      fds_pkg::PH_CONFIRMED: begin
        if (is_key) begin
          event_c     = fds_pkg::EV_RESOLVED;
          buzzer_next = 1'b0;
        end else if (is_tick) begin
          event_c     = fds_pkg::EV_CONFIRMED;
          alert_c     = 1'b1;
          buzzer_next = 1'b1;
        end
      end
      default: begin
        if (is_sample) begin
          // Any idle sample drops the confirmed latch
          fall_latch_next = 1'b0;
          if (suspect) begin
            event_c         = fds_pkg::EV_SUSPECTED;
            angle_ref_next  = req_in.angle;
            step_count_next = 8'd0;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      svm_high       <= fds_pkg::SVM_HIGH_RST;
      still_band     <= fds_pkg::STILL_BAND_RST;
      angle_change   <= fds_pkg::ANGLE_CHANGE_RST;
      settle_samples <= fds_pkg::SETTLE_SAMPLES_RST;
      check_samples  <= fds_pkg::CHECK_SAMPLES_RST;
      alarm_ticks    <= fds_pkg::ALARM_TICKS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fds_pkg::REG_SVM_HIGH:       svm_high       <= cfg_data;
        fds_pkg::REG_STILL_BAND:     still_band     <= cfg_data;
        fds_pkg::REG_ANGLE_CHANGE:   angle_change   <= cfg_data[14:0];
        fds_pkg::REG_SETTLE_SAMPLES: settle_samples <= cfg_data[7:0];
        fds_pkg::REG_CHECK_SAMPLES:  check_samples  <= cfg_data[7:0];
        fds_pkg::REG_ALARM_TICKS:    alarm_ticks    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg  <= fds_pkg::PH_IDLE;
      angle_ref  <= '0;
      step_count <= '0;
      fall_latch <= 1'b0;
      buzzer_reg <= 1'b0;
    end else if (accept) begin
      phase_reg  <= phase_next;
      angle_ref  <= angle_ref_next;
      step_count <= step_count_next;
      fall_latch <= fall_latch_next;
      buzzer_reg <= buzzer_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (res_out.ready) begin
      res_valid <= 1'b0;
    end
  end

  // Hold the result while the sink stalls
  always_ff @(posedge clk) begin
    if (accept) begin
      res_phase  <= phase_next;
      res_buzzer <= buzzer_next;
      res_fall   <= fall_latch_next;
      res_alert  <= alert_c;
      res_event  <= event_c;
    end
  end

  assign res_out.valid        = res_valid;
  assign res_out.phase        = res_phase;
  assign res_out.buzzer       = res_buzzer;
  assign res_out.fall_latched = res_fall;
  assign res_out.send_alert   = res_alert;
  assign res_out.event_res    = res_event;

endmodule

@@ hw/rtl/fds_checker.sv @@
// Port-level checks for the fall-detection sequencer, and the bind onto its top level.
// Depends on fds_pkg and fall_detect_sequencer_unit.
module fds_checker (
  input logic            clk,
  input logic            rst,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input fds_pkg::phase_t phase,
  input logic            buzzer,
  input logic            fall_latched,
  input logic            send_alert,
  input fds_pkg::event_t event_res
);

  // Every request taken shows up as a result on the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("request taken without a result on the next cycle");

  // An alert only goes out from the confirmed phase with the buzzer and flag set
  a_alert_confirmed: assert property (@(posedge clk) disable iff (rst)
    out_valid && send_alert |->
      event_res == fds_pkg::EV_CONFIRMED && phase == fds_pkg::PH_CONFIRMED &&
      buzzer && fall_latched)
    else $error("alert outside the confirmed phase");

  // The buzzer never sounds while idle
  a_idle_silent: assert property (@(posedge clk) disable iff (rst)
    out_valid && phase == fds_pkg::PH_IDLE |-> !buzzer)
    else $error("buzzer on in idle");

  // A stalled result holds its fields
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=>
      out_valid && $stable(phase) && $stable(buzzer) && $stable(fall_latched) &&
      $stable(send_alert) && $stable(event_res))
    else $error("stalled result changed");

endmodule

bind fall_detect_sequencer_unit fds_checker u_fds_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (req_in.valid),
  .in_ready     (req_in.ready),
  .out_valid    (res_out.valid),
  .out_ready    (res_out.ready),
  .phase        (res_out.phase),
  .buzzer       (res_out.buzzer),
  .fall_latched (res_out.fall_latched),
  .send_alert   (res_out.send_alert),
  .event_res    (res_out.event_res)
);

@@ verif/fall_detect_sequencer_unit_test.sv @@
// Testbench for fall_detect_sequencer_unit: drives random and directed requests through
// the valid/ready channels and checks every result against a built-in sequencer predictor.
// Depends on fds_pkg, fds_in_if, fds_out_if and the top level in hw/rtl.
`timescale 1ns / 100ps

module fall_detect_sequencer_unit_test;

  localparam int          CLK_HIGH    = 4;
  localparam int          CLK_LOW     = 4;
  localparam int          CYCLE_LIMIT = 400000;
  localparam logic [1:0]  OP_UNUSED   = 2'd3;

  typedef struct packed {
    fds_pkg::phase_t phase;
    logic            buzzer;
    logic            fall_latched;
    logic            send_alert;
    fds_pkg::event_t event_res;
  } fall_result_t;

  logic                           clk = 1'b0;
  logic                           rst;
  logic                           cfg_we;
  logic [fds_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [fds_pkg::CFG_DATA_W-1:0] cfg_data;

  fds_in_if  req_if ();
  fds_out_if res_if ();

  fall_detect_sequencer_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_in    (req_if),
    .res_out   (res_if)
  );

  // Register mirror
  logic [15:0] cfg_svm_high;
  logic [15:0] cfg_still_band;
  logic [14:0] cfg_angle_change;
  logic [7:0]  cfg_settle;
  logic [7:0]  cfg_check;
  logic [7:0]  cfg_alarm;

  // Sequencer state mirror
  fds_pkg::phase_t    seq_phase;
  logic signed [14:0] seq_angle_ref;
  logic [7:0]         seq_count;
  logic               seq_fall_latch;
  logic               seq_buzzer;

  fall_result_t pending_results[$];
  int           mismatch_count = 0;
  int           cycle_count = 0;
  int unsigned  tx_idle_pct = 0;
  int unsigned  rx_stall_pct = 0;

  always begin
    #CLK_HIGH clk = 1'b1;
    #CLK_LOW  clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      res_if.ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  function automatic void reset_fall_predictor();
    cfg_svm_high     = fds_pkg::SVM_HIGH_RST;
    cfg_still_band   = fds_pkg::STILL_BAND_RST;
    cfg_angle_change = fds_pkg::ANGLE_CHANGE_RST;
    cfg_settle       = fds_pkg::SETTLE_SAMPLES_RST;
    cfg_check        = fds_pkg::CHECK_SAMPLES_RST;
    cfg_alarm        = fds_pkg::ALARM_TICKS_RST;
    seq_phase        = fds_pkg::PH_IDLE;
    seq_angle_ref    = '0;
    seq_count        = '0;
    seq_fall_latch   = 1'b0;
    seq_buzzer       = 1'b0;
  endfunction

  function automatic fall_result_t advance_fall_sequencer(input logic [1:0] op,
                                                          input logic [15:0] svm,
                                                          input logic signed [14:0] ang);
    fall_result_t r;
    int           dev;
    int           chg;
    logic [7:0]   lim;
    r.event_res  = fds_pkg::EV_NONE;
    r.send_alert = 1'b0;
    unique case (seq_phase)
      fds_pkg::PH_SETTLE: begin
        if (op == fds_pkg::OP_SAMPLE) begin
          seq_count = seq_count + 8'd1;
          if (seq_count >= cfg_settle) begin
            seq_count = '0;
            seq_phase = fds_pkg::PH_CHECK;
          end
        end
      end
      fds_pkg::PH_CHECK: begin
        if (op == fds_pkg::OP_SAMPLE) begin
          dev = int'(svm) - int'(fds_pkg::ONE_G);
          if (dev < 0) dev = -dev;
          if (dev > int'(cfg_still_band)) begin
            r.event_res = fds_pkg::EV_MOTION;
            seq_count   = '0;
            seq_phase   = fds_pkg::PH_IDLE;
          end else begin
            seq_count = seq_count + 8'd1;
            lim = (cfg_check == 8'd0) ? 8'd1 : cfg_check;
            if (seq_count >= lim) begin
              seq_count = '0;
              seq_phase = fds_pkg::PH_POSTURE;
            end
          end
        end
      end
      fds_pkg::PH_POSTURE: begin
        if (op == fds_pkg::OP_SAMPLE) begin
          chg = int'(ang) - int'(seq_angle_ref);
          if (chg < 0) chg = -chg;
          seq_count = '0;
          if (chg > int'(cfg_angle_change)) begin
            r.event_res = fds_pkg::EV_ALARM;
            seq_buzzer  = 1'b1;
            seq_phase   = fds_pkg::PH_ALARM;
          end else begin
            r.event_res = fds_pkg::EV_POSTURE;
            seq_phase   = fds_pkg::PH_IDLE;
          end
        end
      end
      fds_pkg::PH_ALARM: begin
        if (op == fds_pkg::OP_KEY) begin
          r.event_res = fds_pkg::EV_CANCELLED;
          seq_buzzer  = 1'b0;
          seq_count   = '0;
          seq_phase   = fds_pkg::PH_IDLE;
        end else if (op == fds_pkg::OP_TICK) begin
          seq_count = seq_count + 8'd1;
          lim = (cfg_alarm == 8'd0) ? 8'd1 : cfg_alarm;
          if (seq_count >= lim) begin
            seq_count      = '0;
            seq_fall_latch = 1'b1;
            seq_buzzer     = 1'b1;
            r.send_alert   = 1'b1;
            r.event_res    = fds_pkg::EV_CONFIRMED;
            seq_phase      = fds_pkg::PH_CONFIRMED;
          end
        end
      end
      fds_pkg::PH_CONFIRMED: begin
        if (op == fds_pkg::OP_KEY) begin
          r.event_res = fds_pkg::EV_RESOLVED;
          seq_buzzer  = 1'b0;
          seq_phase   = fds_pkg::PH_IDLE;
        end else if (op == fds_pkg::OP_TICK) begin
          r.send_alert = 1'b1;
          r.event_res  = fds_pkg::EV_CONFIRMED;
          seq_buzzer   = 1'b1;
        end
      end
      default: begin
        if (op == fds_pkg::OP_SAMPLE) begin
          seq_fall_latch = 1'b0;
          seq_phase      = fds_pkg::PH_IDLE;
          if (svm > cfg_svm_high) begin
            r.event_res   = fds_pkg::EV_SUSPECTED;
            seq_angle_ref = ang;
            seq_count     = '0;
            seq_phase     = (cfg_settle == 8'd0) ? fds_pkg::PH_CHECK : fds_pkg::PH_SETTLE;
          end
        end
      end
    endcase
    r.phase        = seq_phase;
    r.buzzer       = seq_buzzer;
    r.fall_latched = seq_fall_latch;
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  always @(posedge clk) begin
    fall_result_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        want = pending_results.pop_front();
        if (res_if.phase !== want.phase)
          report_mismatch($sformatf("phase %0d, expected %0d", res_if.phase, want.phase));
        if (res_if.buzzer !== want.buzzer)
          report_mismatch($sformatf("buzzer %0b, expected %0b", res_if.buzzer, want.buzzer));
        if (res_if.fall_latched !== want.fall_latched)
          report_mismatch($sformatf("fall_latched %0b, expected %0b",
                                    res_if.fall_latched, want.fall_latched));
        if (res_if.send_alert !== want.send_alert)
          report_mismatch($sformatf("send_alert %0b, expected %0b",
                                    res_if.send_alert, want.send_alert));
        if (res_if.event_res !== want.event_res)
          report_mismatch($sformatf("event_res %0d, expected %0d",
                                    res_if.event_res, want.event_res));
      end
    end
  end

  // Hold valid until the request is taken, then predict its result
  task automatic send_request(input logic [1:0] op, input logic [15:0] svm,
                              input logic signed [14:0] ang);
    while ($urandom_range(99) < tx_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid     <= 1'b1;
    req_if.operation <= op;
    req_if.svm       <= svm;
    req_if.angle     <= ang;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    pending_results.push_back(advance_fall_sequencer(op, svm, ang));
  endtask

  task automatic wait_results_drained();
    req_if.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic apply_settings(input logic [15:0] svm_high, input logic [15:0] still_band,
                                input logic [14:0] angle_chg, input logic [7:0] settle,
                                input logic [7:0] check, input logic [7:0] alarm);
    logic [fds_pkg::CFG_IDX_W-1:0]  idx  [6];
    logic [fds_pkg::CFG_DATA_W-1:0] vals [6];
    wait_results_drained();
    idx[0] = fds_pkg::REG_SVM_HIGH;       vals[0] = svm_high;
    idx[1] = fds_pkg::REG_STILL_BAND;     vals[1] = still_band;
    idx[2] = fds_pkg::REG_ANGLE_CHANGE;   vals[2] = {1'b0, angle_chg};
    idx[3] = fds_pkg::REG_SETTLE_SAMPLES; vals[3] = {8'd0, settle};
    idx[4] = fds_pkg::REG_CHECK_SAMPLES;  vals[4] = {8'd0, check};
    idx[5] = fds_pkg::REG_ALARM_TICKS;    vals[5] = {8'd0, alarm};
    for (int i = 0; i < 6; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    cfg_svm_high     = svm_high;
    cfg_still_band   = still_band;
    cfg_angle_change = angle_chg;
    cfg_settle       = settle;
    cfg_check        = check;
    cfg_alarm        = alarm;
  endtask

  // Pick the next request from the predicted phase, so most of the traffic
  // walks the whole fall sequence; steering keeps it on course for the alert.
  task automatic send_guided_item(input bit steer);
    int unsigned        pick;
    logic [1:0]         op;
    logic [15:0]        svm;
    logic signed [14:0] ang;
    int                 lo;
    int                 hi;
    int                 d;
    int                 a;
    pick = $urandom_range(99);
    op   = fds_pkg::OP_SAMPLE;
    svm  = 16'($urandom_range(65535, 0));
    ang  = 15'($urandom_range(32767, 0));
    unique case (seq_phase)
      fds_pkg::PH_IDLE: begin
        if (pick < 60) begin
          if (cfg_svm_high != 16'hFFFF)
            svm = 16'($urandom_range(65535, int'(cfg_svm_high) + 1));
        end else if (pick < 85) begin
          svm = 16'($urandom_range(int'(cfg_svm_high), 0));
        end else begin
          op = 2'($urandom_range(3, 1));
        end
      end
      fds_pkg::PH_SETTLE: begin
        if (pick >= 85) op = 2'($urandom_range(3, 1));
      end
      fds_pkg::PH_CHECK: begin
        lo = int'(fds_pkg::ONE_G) - int'(cfg_still_band);
        hi = int'(fds_pkg::ONE_G) + int'(cfg_still_band);
        if (lo < 0) lo = 0;
        if (hi > 65535) hi = 65535;
        if (pick < 88 || steer) begin
          svm = 16'($urandom_range(hi, lo));
        end else if (pick < 94) begin
          if (hi < 65535) svm = 16'($urandom_range(65535, hi + 1));
          else if (lo > 0) svm = 16'($urandom_range(lo - 1, 0));
        end else begin
          op = 2'($urandom_range(3, 1));
        end
      end
      fds_pkg::PH_POSTURE: begin
        if (pick < 90 || steer) begin
          if (steer || pick < 45) d = $urandom_range(32767, int'(cfg_angle_change) + 1);
          else d = $urandom_range(int'(cfg_angle_change), 0);
          // move away from the reference in the direction with more room
          a = (int'(seq_angle_ref) >= 0) ? int'(seq_angle_ref) - d : int'(seq_angle_ref) + d;
          if (a < -16384) a = -16384;
          if (a > 16383) a = 16383;
          ang = 15'(a);
        end else begin
          op = 2'($urandom_range(3, 1));
        end
      end
      fds_pkg::PH_ALARM: begin
        if (pick < 70) op = fds_pkg::OP_TICK;
        else if (pick < 78 && !steer) op = fds_pkg::OP_KEY;
        else if (pick < 90) op = fds_pkg::OP_SAMPLE;
        else op = OP_UNUSED;
      end
      fds_pkg::PH_CONFIRMED: begin
        if (pick < 50) op = fds_pkg::OP_TICK;
        else if (pick < 75) op = fds_pkg::OP_KEY;
        else if (pick < 88) op = fds_pkg::OP_SAMPLE;
        else op = OP_UNUSED;
      end
      default: op = 2'($urandom_range(3, 0));
    endcase
    send_request(op, svm, ang);
  endtask

  task automatic test_directed();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    // reset settings: ignored requests and thresholds at their edges
    send_request(OP_UNUSED, 16'hFFFF, -15'sd16384);
    send_request(fds_pkg::OP_TICK, 16'hFFFF, 15'sd16383);
    send_request(fds_pkg::OP_KEY, 16'd0, 15'sd0);
    send_request(fds_pkg::OP_SAMPLE, 16'd0, 15'sd0);
    send_request(fds_pkg::OP_SAMPLE, 16'd8192, 15'sd16383);
    // no settle, check and alarm counts of zero act as one
    apply_settings(16'd8192, 16'd1024, 15'd3840, 8'd0, 8'd0, 8'd0);
    send_request(fds_pkg::OP_SAMPLE, 16'hFFFF, -15'sd16384);
    send_request(fds_pkg::OP_SAMPLE, 16'd5120, 15'sd0);
    send_request(fds_pkg::OP_SAMPLE, 16'd0, 15'sd16383);
    send_request(fds_pkg::OP_SAMPLE, 16'd4096, 15'sd0);
    send_request(OP_UNUSED, 16'd0, 15'sd0);
    send_request(fds_pkg::OP_TICK, 16'd0, 15'sd0);
    send_request(fds_pkg::OP_TICK, 16'd0, 15'sd0);
    send_request(fds_pkg::OP_SAMPLE, 16'hFFFF, 15'sd0);
    send_request(fds_pkg::OP_KEY, 16'd0, 15'sd0);
    send_request(fds_pkg::OP_SAMPLE, 16'd100, 15'sd0);
    // motion reject just outside the band
    send_request(fds_pkg::OP_SAMPLE, 16'd8193, 15'sd100);
    send_request(fds_pkg::OP_SAMPLE, 16'd3071, 15'sd0);
    // posture reject on a change equal to the threshold
    send_request(fds_pkg::OP_SAMPLE, 16'hFFFF, 15'sd0);
    send_request(fds_pkg::OP_SAMPLE, 16'd4096, 15'sd0);
    send_request(fds_pkg::OP_SAMPLE, 16'd4096, 15'sd3840);
    // alarm then cancel by key
    send_request(fds_pkg::OP_SAMPLE, 16'hFFFF, 15'sd11520);
    send_request(fds_pkg::OP_SAMPLE, 16'd4096, 15'sd0);
    send_request(fds_pkg::OP_SAMPLE, 16'd4096, -15'sd11520);
    send_request(fds_pkg::OP_KEY, 16'd0, 15'sd0);
  endtask

  task automatic test_extreme_low();
    apply_settings(16'd0, 16'd0, 15'd0, 8'd0, 8'd0, 8'd0);
    repeat (100) send_guided_item(1'b0);
  endtask

  task automatic test_random_traffic(input int unsigned tx_pct, input int unsigned rx_pct);
    apply_settings(16'($urandom_range(60000, 0)), 16'($urandom_range(3000, 0)),
                   15'($urandom_range(23040, 0)), 8'($urandom_range(4, 0)),
                   8'($urandom_range(4, 0)), 8'($urandom_range(5, 0)));
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    repeat (180) begin
      if ($urandom_range(99) == 0) wait_results_drained();
      send_guided_item(1'b0);
    end
  endtask

  task automatic test_extreme_high();
    apply_settings(16'hFFFF, 16'hFFFF, 15'd23040, 8'd255, 8'd255, 8'd255);
    tx_idle_pct  = 29;
    rx_stall_pct = 29;
    repeat (60) send_guided_item(1'b0);
  endtask

  // Full-length counters: run one fall through settle, check and alarm to the alert
  task automatic test_long_counts();
    bit saw_settle;
    bit reached;
    int n;
    apply_settings(16'd8192, 16'hFFFF, 15'd0, 8'd255, 8'd255, 8'd255);
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    saw_settle = 1'b0;
    reached    = 1'b0;
    n          = 0;
    while (n < 1500 && !(reached && seq_phase == fds_pkg::PH_IDLE)) begin
      send_guided_item(1'b1);
      if (seq_phase == fds_pkg::PH_SETTLE) saw_settle = 1'b1;
      if (saw_settle && seq_phase == fds_pkg::PH_CONFIRMED) reached = 1'b1;
      n++;
    end
  endtask

  initial begin
    rst              <= 1'b1;
    cfg_we           <= 1'b0;
    cfg_index        <= '0;
    cfg_data         <= '0;
    req_if.valid     <= 1'b0;
    req_if.operation <= fds_pkg::OP_SAMPLE;
    req_if.svm       <= '0;
    req_if.angle     <= '0;
    reset_fall_predictor();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_extreme_low();
    test_random_traffic(0, 0);
    test_random_traffic(75, 0);
    test_random_traffic(0, 75);
    test_random_traffic(29, 29);
    test_extreme_high();
    test_long_counts();

    wait_results_drained();
    if (mismatch_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
